>>> sv/icb_pkg.sv
`timescale 1ns / 1ps
package icb_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int PRODUCT_BITS  = 32;
  localparam int IDXW          = 5;
  localparam int RW            = 34;
  localparam int ZW            = 34;
  localparam int VW            = PRODUCT_BITS + 4;
  localparam int PROD_SHIFT    = 62 - PRODUCT_BITS;
  localparam int VLEN          = 2 * CORDIC_STAGES + 4;

  localparam logic signed [RW-1:0] GAIN_INIT = RW'(652032874);
  localparam logic signed [31:0]   Q_ONE     = 32'sh4000_0000;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 special;
    logic [1:0]           quad;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
    logic                 deg;
  } vec_t;

  function automatic logic [31:0] atan_at(input logic [IDXW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> sv/icb_rot_cell.sv
`timescale 1ns / 1ps
module icb_rot_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [icb_pkg::IDXW-1:0] idx,
  input  icb_pkg::rot_t         d_i,
  output icb_pkg::rot_t         d_o
);

  icb_pkg::rot_t d_r, d_nxt;
  logic signed [icb_pkg::RW-1:0] dx, dy;
  logic signed [icb_pkg::ZW-1:0] at;

  always_comb begin
    dx = d_i.y >>> idx;
    dy = d_i.x >>> idx;
    at = icb_pkg::ZW'(icb_pkg::atan_at(idx));
    d_nxt = d_i;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

>>> sv/icb_vec_cell.sv
`timescale 1ns / 1ps
module icb_vec_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [icb_pkg::IDXW-1:0] idx,
  input  icb_pkg::vec_t         d_i,
  output icb_pkg::vec_t         d_o
);

  icb_pkg::vec_t d_r, d_nxt;
  logic signed [icb_pkg::VW-1:0] dx, dy;
  logic [31:0] at;

  always_comb begin
    dx = d_i.y >>> idx;
    dy = d_i.x >>> idx;
    at = icb_pkg::atan_at(idx);
    d_nxt = d_i;
    if (d_i.y > 0) begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end else begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

>>> sv/initial_bearing_great_circle.sv
`timescale 1ns / 1ps
// Initial great-circle bearing, fully pipelined.
// Input channel in_*: one item per origin/destination pair, four 32-bit
// binary angles (2^31 = 180 degrees) packed in in_tdata.
// Output channel out_*: out_tdata is the 16-bit bearing (65536 = 360
// degrees), out_tuser is the degenerate flag (x and y both zero, bearing 0).
// Path from accept to out_tvalid: one setup stage, a chain of rotation
// cells for the three sines/cosines, three multiply stages, a chain of
// vectoring cells and the output register.
// Throughput: one item per cycle while the output is not stalled; every
// cell stage takes a new item each cycle unless the pipeline holds.
// Stall: when out_tvalid is high and out_tready low, the whole pipeline
// holds and in_tready drops; nothing is lost or repeated.
// Reset: rst_n low (synchronous) empties the pipeline and clears out_tvalid;
// the payload registers need no reset.
module initial_bearing_great_circle (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_lat[31:0], origin_lon[63:32], dest_lat[95:64], dest_lon[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bearing[15:0]
  output logic [15:0]  out_tdata,
  // degenerate[0]
  output logic         out_tuser
);

  localparam int N = icb_pkg::CORDIC_STAGES;

  logic en;
  logic [icb_pkg::VLEN-1:0] v_r;
  logic out_tvalid_r;
  logic [15:0] bearing_r;
  logic degen_r;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  icb_pkg::rot_t rc [3][N+1];
  icb_pkg::vec_t vc [N+1];

  function automatic icb_pkg::rot_t prep(input logic [31:0] a);
    icb_pkg::rot_t r;
    logic [31:0] f;
    r.special = (a[29:0] == 30'd0);
    r.quad = a[31:30];
    r.neg = 1'b0;
    f = a;
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 32'd0) begin
      f = a - 32'h8000_0000;
      r.neg = 1'b1;
    end
    r.x = icb_pkg::GAIN_INIT;
    r.y = '0;
    r.z = icb_pkg::ZW'($signed(f));
    return r;
  endfunction

  function automatic logic signed [31:0] fin_s(input icb_pkg::rot_t r);
    logic signed [31:0] v;
    if (r.special) begin
      case (r.quad)
        icb_pkg::QUAD_0:   v = '0;
        icb_pkg::QUAD_90:  v = icb_pkg::Q_ONE;
        icb_pkg::QUAD_180: v = '0;
        default:           v = -icb_pkg::Q_ONE;
      endcase
    end else begin
      v = r.neg ? -r.y[31:0] : r.y[31:0];
    end
    return v;
  endfunction

  function automatic logic signed [31:0] fin_c(input icb_pkg::rot_t r);
    logic signed [31:0] v;
    if (r.special) begin
      case (r.quad)
        icb_pkg::QUAD_0:   v = icb_pkg::Q_ONE;
        icb_pkg::QUAD_90:  v = '0;
        icb_pkg::QUAD_180: v = -icb_pkg::Q_ONE;
        default:           v = '0;
      endcase
    end else begin
      v = r.neg ? -r.x[31:0] : r.x[31:0];
    end
    return v;
  endfunction

  icb_pkg::rot_t pre_r [3];
  logic [31:0] dlon;
  assign dlon = in_tdata[127:96] - in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r[0] <= prep(in_tdata[31:0]);
      pre_r[1] <= prep(in_tdata[95:64]);
      pre_r[2] <= prep(dlon);
    end
  end

  genvar g, k;
  generate
    for (k = 0; k < 3; k++) begin : g_ang
      assign rc[k][0] = pre_r[k];
      for (g = 0; g < N; g++) begin : g_rot
        icb_rot_cell u_cell (
          .clk (clk),
          .en  (en),
          .idx (icb_pkg::IDXW'(g)),
          .d_i (rc[k][g]),
          .d_o (rc[k][g+1])
        );
      end
    end
  endgenerate

  logic signed [31:0] s1, c1, s2, c2, sd, cd;
  assign s1 = fin_s(rc[0][N]);
  assign c1 = fin_c(rc[0][N]);
  assign s2 = fin_s(rc[1][N]);
  assign c2 = fin_c(rc[1][N]);
  assign sd = fin_s(rc[2][N]);
  assign cd = fin_c(rc[2][N]);

  logic signed [63:0] py_r, pa_r, pcd_r;
  logic signed [31:0] s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      py_r  <= sd * c2;
      pa_r  <= c1 * s2;
      pcd_r <= c2 * cd;
      s1_r  <= s1;
    end
  end

  logic signed [63:0] pcd_sh, py_sh, pa_sh;
  logic signed [31:0] c2cd;
  assign pcd_sh = pcd_r >>> 30;
  assign c2cd   = pcd_sh[31:0];
  assign py_sh  = py_r >>> icb_pkg::PROD_SHIFT;
  assign pa_sh  = pa_r >>> icb_pkg::PROD_SHIFT;

  logic signed [63:0] pb_r;
  logic signed [icb_pkg::VW-1:0] y2_r, a2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r <= s1_r * c2cd;
      y2_r <= py_sh[icb_pkg::VW-1:0];
      a2_r <= pa_sh[icb_pkg::VW-1:0];
    end
  end

  logic signed [63:0] pb_sh;
  logic signed [icb_pkg::VW-1:0] xv;
  icb_pkg::vec_t vin_nxt, vin_r;
  assign pb_sh = pb_r >>> icb_pkg::PROD_SHIFT;
  assign xv = a2_r - pb_sh[icb_pkg::VW-1:0];

  always_comb begin
    vin_nxt.deg = (xv == '0) && (y2_r == '0);
    if (xv < 0) begin
      vin_nxt.x = -xv;
      vin_nxt.y = -y2_r;
      vin_nxt.z = 32'h8000_0000;
    end else begin
      vin_nxt.x = xv;
      vin_nxt.y = y2_r;
      vin_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vin_r <= vin_nxt;
    end
  end

  assign vc[0] = vin_r;
  generate
    for (g = 0; g < N; g++) begin : g_vec
      icb_vec_cell u_cell (
        .clk (clk),
        .en  (en),
        .idx (icb_pkg::IDXW'(g)),
        .d_i (vc[g]),
        .d_o (vc[g+1])
      );
    end
  endgenerate

  logic [31:0] zr;
  assign zr = vc[N].z + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v_r          <= {v_r[icb_pkg::VLEN-2:0], in_tvalid};
      out_tvalid_r <= v_r[icb_pkg::VLEN-1];
    end
    if (en) begin
      bearing_r <= vc[N].deg ? 16'd0 : zr[31:16];
      degen_r   <= vc[N].deg;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = bearing_r;
  assign out_tuser  = degen_r;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 16'd0))
    else $error("degenerate item with nonzero bearing");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(v_r) && out_tvalid))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && (v_r == '0)))
    else $error("pipeline not empty after reset");
`endif

endmodule
